// File: src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define FCC_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent (overlapping or not, as written by the caller).
`define FCC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: src/fccal_pkg.sv
// Package for the frame clock calendar timer: item codes, widths, reset values.
// No dependencies; imported by all timer modules.
package fccal_pkg;

    localparam int KIND_W      = 3;
    localparam int PORT_W      = 8;
    localparam int WORD_W      = 32;
    localparam int SEC_W       = 17;
    localparam int FIS_W       = 6;
    localparam int CFG_INDEX_W = 2;

    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FRAME = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    localparam logic [PORT_W-1:0] PORT_DATE   = 8'd0;
    localparam logic [PORT_W-1:0] PORT_TIME   = 8'd1;
    localparam logic [PORT_W-1:0] PORT_FRAMES = 8'd2;
    localparam logic [PORT_W-1:0] PORT_CYCLES = 8'd3;

    localparam logic [CFG_INDEX_W-1:0] CFG_START_DATE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_SECONDS = 2'd1;

    localparam logic [WORD_W-1:0] START_DATE_RST    = 32'd131072000;
    localparam logic [SEC_W-1:0]  START_SECONDS_RST = 17'd0;

    localparam logic [FIS_W-1:0]  FRAMES_PER_SEC = 6'd60;
    localparam logic [SEC_W-1:0]  SECS_PER_DAY   = 17'd86400;
    localparam logic [15:0]       DAYS_LEAP      = 16'd366;
    localparam logic [15:0]       DAYS_COMMON    = 16'd365;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [PORT_W-1:0] port;
    } item_t;

    // year % 4 == 0 and year % 100 != 0; /100 by reciprocal 5243 / 2^19
    function automatic logic is_leap(input logic [15:0] year);
        logic [28:0] prod;
        logic [9:0]  quo;
        logic [15:0] hund;
        prod = {13'd0, year} * 29'd5243;
        quo  = prod[28:19];
        hund = {quo, 6'd0} + {1'b0, quo, 5'd0} + {4'd0, quo, 2'd0};
        return (year[1:0] == 2'd0) && (hund != year);
    endfunction

endpackage

// File: src/frame_clock_calendar_timer.sv
// Frame clock calendar timer: accepts one word per clock on the input stream and
// answers reads and writes via the input register and a registered output word.
// Each word is registered, then handled in one registered pass of the core
// (counters, calendar, read mux), so the rate is one word per clock as long as
// the output is drained; a stalled output holds only words that carry a result.
// Configuration writes (0 start date, 1 start seconds) load the date or time of
// day at once and are always taken. Depends on fccal_pkg, fccal_in_reg, fccal_core.
module frame_clock_calendar_timer
    import fccal_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [7:0]             s_tdata,   // port[7:0]
    input  logic [2:0]             s_tuser,   // kind[2:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,   // read_data[31:0]
    output logic                   m_tuser,   // ok
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    logic  take;
    logic  item_valid;
    item_t item;

    assign cfg_ready = 1'b1;

    fccal_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    fccal_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .cfg_wr     (cfg_valid && cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

endmodule

// File: src/fccal_in_reg.sv
// Input register stage for the timer: holds one word until the core takes it.
// Depends on fccal_pkg.
module fccal_in_reg
    import fccal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // port[7:0]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    input  logic        take,
    output logic        item_valid,
    output item_t       item
);

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            item_reg.kind <= s_tuser;
            item_reg.port <= s_tdata;
        end
    end

endmodule

// File: src/fccal_core.sv
// Timer core: counters, calendar, leap lookahead and the result register.
// Depends on fccal_pkg.
module fccal_core
    import fccal_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  item_t                  item,
    output logic                   take,
    input  logic                   cfg_wr,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]      cfg_data,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [31:0]            m_tdata,  // read_data[31:0]
    output logic                   m_tuser   // ok
);

    logic [WORD_W-1:0] cycle_reg, cycle_next;
    logic [WORD_W-1:0] frame_reg, frame_next;
    logic [FIS_W-1:0]  fis_reg, fis_next;
    logic [SEC_W-1:0]  sec_reg, sec_next;
    logic [WORD_W-1:0] date_reg, date_next;
    logic              leap_cur_reg, leap_nxt_reg;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_data_reg, out_data_next;
    logic              out_ok_reg, out_ok_next;

    logic              has_result;
    logic [FIS_W-1:0]  fis_inc;
    logic [SEC_W-1:0]  sec_adv;
    logic [WORD_W-1:0] date_inc;
    logic              leap;
    logic [15:0]       year_len;
    logic [15:0]       leap_year;

    assign has_result = (item.kind == KIND_READ) || (item.kind == KIND_WRITE);
    assign take       = item_valid && (!has_result || !out_valid_reg || m_tready);

    // a date load feeds the lookahead directly
    assign leap_year = (cfg_wr && (cfg_index == CFG_START_DATE)) ? cfg_data[31:16]
                                                                  : date_reg[31:16];

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

    always_comb
    begin
        cycle_next     = cycle_reg;
        frame_next     = frame_reg;
        fis_next       = fis_reg;
        sec_next       = sec_reg;
        date_next      = date_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_ok_next    = out_ok_reg;

        fis_inc  = fis_reg + 6'd1;
        sec_adv  = (fis_inc >= FRAMES_PER_SEC) ? sec_reg + 17'd1 : sec_reg;
        date_inc = date_reg + 32'd1;
        leap     = (date_reg[15:0] == 16'hFFFF) ? leap_nxt_reg : leap_cur_reg;
        year_len = leap ? DAYS_LEAP : DAYS_COMMON;

        if (take)
        begin
            case (item.kind)
                KIND_TICK:
                begin
                    cycle_next = cycle_reg + 32'd1;
                end
                KIND_FRAME:
                begin
                    cycle_next = '0;
                    frame_next = frame_reg + 32'd1;
                    fis_next   = (fis_inc >= FRAMES_PER_SEC) ? '0 : fis_inc;
                    sec_next   = sec_adv;
                    if (sec_adv >= SECS_PER_DAY)
                    begin
                        sec_next = '0;
                        if (date_inc[15:0] >= year_len)
                            date_next = {date_inc[31:16] + 16'd1, 16'd0};
                        else
                            date_next = date_inc;
                    end
                end
                KIND_READ:
                begin
                    out_valid_next = 1'b1;
                    out_ok_next    = 1'b1;
                    case (item.port)
                        PORT_DATE:   out_data_next = date_reg;
                        PORT_TIME:   out_data_next = {15'd0, sec_reg};
                        PORT_FRAMES: out_data_next = frame_reg;
                        PORT_CYCLES: out_data_next = cycle_reg;
                        default:
                        begin
                            out_data_next = '0;
                            out_ok_next   = 1'b0;
                        end
                    endcase
                end
                KIND_WRITE:
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_ok_next    = 1'b0;
                end
                KIND_CLEAR:
                begin
                    cycle_next = '0;
                    frame_next = '0;
                    fis_next   = '0;
                end
                default:
                begin
                end
            endcase
        end

        if (cfg_wr)
        begin
            case (cfg_index)
                CFG_START_DATE:    date_next = cfg_data;
                CFG_START_SECONDS: sec_next  = cfg_data[SEC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_reg     <= '0;
            frame_reg     <= '0;
            fis_reg       <= '0;
            sec_reg       <= START_SECONDS_RST;
            date_reg      <= START_DATE_RST;
            leap_cur_reg  <= is_leap(START_DATE_RST[31:16]);
            leap_nxt_reg  <= is_leap(START_DATE_RST[31:16] + 16'd1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cycle_reg     <= cycle_next;
            frame_reg     <= frame_next;
            fis_reg       <= fis_next;
            sec_reg       <= sec_next;
            date_reg      <= date_next;
            // year length lookahead; the year never rolls over in consecutive cycles
            leap_cur_reg  <= is_leap(leap_year);
            leap_nxt_reg  <= is_leap(leap_year + 16'd1);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_ok_reg   <= out_ok_next;
    end

endmodule

// File: src/fccal_checker.sv
// Port-level checker for the frame clock calendar timer, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module fccal_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    logic        in_accept;
    logic        out_stall;
    logic [32:0] out_word;

    assign in_accept = s_tvalid && s_tready;
    assign out_stall = m_tvalid && !m_tready;
    assign out_word  = {m_tuser, m_tdata};

    // a held output word must not change
    `FCC_ASSERT_IMP(a_out_hold, out_stall, ##1 (m_tvalid && $stable(out_word)), "held word changed")

    // failed access always reads back zero
    `FCC_ASSERT_IMP(a_fail_zero, m_tvalid && !m_tuser, m_tdata == 32'd0, "failed access, nonzero data")

    // a new result follows an accepted input word through the input and result registers
    `FCC_ASSERT_IMP(a_out_cause, $rose(m_tvalid), $past(in_accept, 2), "result without input word")

endmodule

bind frame_clock_calendar_timer fccal_checker u_fccal_checker (.*);
